FILE: rtl/lcbs_pkg.sv
// Shared types and constants for the blob label/statistics block.
// Holds the channel word layouts, request codes and controller/datapath
// command and status groups. No dependencies.
package lcbs_pkg;

    localparam int COORD_W = 10;
    localparam int LABEL_W = 16;
    localparam int ID_W    = 10;
    localparam int CENT_W  = 10;
    localparam int SUM_W   = 30;
    localparam int CNT_W   = 21;
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STATS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam int DIV_CNT_W = $clog2(CENT_W + 1);

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [ID_W-1:0]    blob_index;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]   blob_id;
        logic              is_new;
        logic              overflow;
        logic [CENT_W-1:0] centroid_x;
        logic [CENT_W-1:0] centroid_y;
        logic [CNT_W-1:0]  area;
        logic              stat_valid;
    } out_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_stats;
        logic div_last;
        logic out_free;
        logic clearing;
    } status_t;

endpackage

FILE: rtl/lcbs_ctrl.sv
// Sequencing state machine for the blob label/statistics block.
// Issues commands to lcbs_dp and reads back its status. Uses lcbs_pkg.
module lcbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lcbs_pkg::status_t status,
    output lcbs_pkg::cmd_t    cmd,
    output logic              busy
);
    import lcbs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // hold off while the label table is being zeroed
                if (in_valid && !status.clearing)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = status.is_stats ? ST_LOAD : ST_DONE;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register can take it
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE) || status.clearing;

endmodule

FILE: rtl/lcbs_dp.sv
// Datapath of the blob label/statistics block: label and blob memories,
// saturating accumulators, centroid divider and output register.
// Driven by lcbs_ctrl. Uses lcbs_pkg.
module lcbs_dp #(
    parameter int LABEL_BITS = 16,
    parameter int MAX_BLOBS  = 1024,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lcbs_pkg::in_t     in_data,
    input  logic              out_stall,
    input  lcbs_pkg::cmd_t    cmd,
    output lcbs_pkg::status_t status,
    output logic              out_valid,
    output lcbs_pkg::out_t    out_data
);
    import lcbs_pkg::*;

    localparam int BID_W     = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int BCNT_W    = $clog2(MAX_BLOBS + 1);
    localparam int TBL_DEPTH = 1 << LABEL_BITS;
    localparam int HI_W      = SUM_W - CENT_W;

    // label -> blob id (zeroed by a pass after reset; checked against owner_mem)
    logic [BID_W-1:0]      label_mem [TBL_DEPTH];
    // blob id -> owning label, written when the blob is created
    logic [LABEL_BITS-1:0] owner_mem [MAX_BLOBS];
    logic [SUM_W-1:0]      sumx_mem  [MAX_BLOBS];
    logic [SUM_W-1:0]      sumy_mem  [MAX_BLOBS];
    logic [CNT_W-1:0]      cnt_mem   [MAX_BLOBS];

    in_t                   item_reg;
    logic [BID_W-1:0]      tbl_id_reg;
    logic [LABEL_BITS-1:0] owner_reg;
    logic [SUM_W-1:0]      sx_reg;
    logic [SUM_W-1:0]      sy_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [BCNT_W-1:0]     blob_count_reg;
    logic [BCNT_W-1:0]     blob_count_next;
    logic                  clearing_reg;
    logic [LABEL_BITS-1:0] clr_addr_reg;

    logic [CENT_W-1:0]     qx_reg, qy_reg, qx_next, qy_next;
    logic [CENT_W-1:0]     dlx_reg, dly_reg;
    logic [CNT_W-1:0]      remx_reg, remy_reg, remx_next, remy_next;
    logic                  satx_reg, saty_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;

    out_t                  out_reg;
    out_t                  out_next;
    logic                  out_valid_reg;

    logic [LABEL_BITS-1:0] lbl_in;
    logic [LABEL_BITS-1:0] lbl_item;
    logic [BID_W-1:0]      blob_raddr;
    logic [BID_W-1:0]      blob_waddr;
    logic [BID_W-1:0]      new_id;
    logic [BID_W-1:0]      pix_id;
    logic                  is_pixel;
    logic                  hit;
    logic                  can_new;
    logic                  do_new;
    logic                  do_upd;
    logic                  ovf;
    logic                  stat_ok;
    logic [COORD_W-1:0]    px;
    logic [COORD_W-1:0]    py;
    logic [SUM_W:0]        sx_add;
    logic [SUM_W:0]        sy_add;
    logic [CNT_W:0]        n_add;
    logic [SUM_W-1:0]      sx_wdata;
    logic [SUM_W-1:0]      sy_wdata;
    logic [CNT_W-1:0]      n_wdata;
    logic [CNT_W:0]        r2x, r2y;
    logic                  gex, gey;
    logic [CENT_W-1:0]     cx, cy;

    assign lbl_in   = LABEL_BITS'(in_data.label);
    assign lbl_item = LABEL_BITS'(item_reg.label);
    assign is_pixel = (item_reg.req_type == REQ_PIXEL);

    // clamp coordinates to the frame
    assign px = (32'(item_reg.pos_x) > 32'(MAX_WIDTH - 1))
              ? COORD_W'(MAX_WIDTH - 1) : item_reg.pos_x;
    assign py = (32'(item_reg.pos_y) > 32'(MAX_HEIGHT - 1))
              ? COORD_W'(MAX_HEIGHT - 1) : item_reg.pos_y;

    // an entry is live only if it points below the count and the blob owns it
    assign hit     = (BCNT_W'(tbl_id_reg) < blob_count_reg) && (owner_reg == lbl_item);
    assign can_new = (blob_count_reg < BCNT_W'(MAX_BLOBS));
    assign new_id  = BID_W'(blob_count_reg);
    assign do_new  = is_pixel && !hit && can_new;
    assign do_upd  = is_pixel && (hit || can_new);
    assign ovf     = is_pixel && !hit && !can_new;
    assign pix_id  = hit ? tbl_id_reg : new_id;

    assign blob_raddr = is_pixel ? tbl_id_reg : BID_W'(item_reg.blob_index);
    assign blob_waddr = pix_id;

    assign sx_add = {1'b0, sx_reg} + (SUM_W + 1)'(px);
    assign sy_add = {1'b0, sy_reg} + (SUM_W + 1)'(py);
    assign n_add  = {1'b0, n_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        if (hit)
        begin
            sx_wdata = sx_add[SUM_W] ? '1 : sx_add[SUM_W-1:0];
            sy_wdata = sy_add[SUM_W] ? '1 : sy_add[SUM_W-1:0];
            n_wdata  = n_add[CNT_W]  ? '1 : n_add[CNT_W-1:0];
        end
        else
        begin
            // fresh blob: start accumulators at this pixel
            sx_wdata = SUM_W'(px);
            sy_wdata = SUM_W'(py);
            n_wdata  = CNT_W'(1);
        end
    end

    // walk the label table once after reset, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + LABEL_BITS'(1);
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // label table
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            label_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.finish && do_new)
        begin
            label_mem[lbl_item] <= new_id;
        end
        if (cmd.capture)
        begin
            tbl_id_reg <= label_mem[lbl_in];
        end
    end

    // per-blob memories
    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_new)
        begin
            owner_mem[blob_waddr] <= lbl_item;
        end
        if (cmd.finish && do_upd)
        begin
            sumx_mem[blob_waddr] <= sx_wdata;
            sumy_mem[blob_waddr] <= sy_wdata;
            cnt_mem[blob_waddr]  <= n_wdata;
        end
        if (cmd.fetch)
        begin
            owner_reg <= owner_mem[blob_raddr];
            sx_reg    <= sumx_mem[blob_raddr];
            sy_reg    <= sumy_mem[blob_raddr];
            n_reg     <= cnt_mem[blob_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    // restoring divider, one quotient bit per cycle on each axis
    assign r2x = {remx_reg, dlx_reg[CENT_W-1]};
    assign r2y = {remy_reg, dly_reg[CENT_W-1]};
    assign gex = (r2x >= {1'b0, n_reg});
    assign gey = (r2y >= {1'b0, n_reg});
    assign remx_next = gex ? CNT_W'(r2x - {1'b0, n_reg}) : CNT_W'(r2x);
    assign remy_next = gey ? CNT_W'(r2y - {1'b0, n_reg}) : CNT_W'(r2y);
    assign qx_next   = {qx_reg[CENT_W-2:0], gex};
    assign qy_next   = {qy_reg[CENT_W-2:0], gey};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // quotient above the field saturates: high part already >= divisor
            satx_reg <= (CNT_W'(sx_reg[SUM_W-1:CENT_W]) >= n_reg);
            saty_reg <= (CNT_W'(sy_reg[SUM_W-1:CENT_W]) >= n_reg);
            remx_reg <= CNT_W'(sx_reg[SUM_W-1:SUM_W-HI_W]);
            remy_reg <= CNT_W'(sy_reg[SUM_W-1:SUM_W-HI_W]);
            dlx_reg  <= sx_reg[CENT_W-1:0];
            dly_reg  <= sy_reg[CENT_W-1:0];
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            dlx_reg  <= {dlx_reg[CENT_W-2:0], 1'b0};
            dly_reg  <= {dly_reg[CENT_W-2:0], 1'b0};
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= DIV_CNT_W'(CENT_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign stat_ok = (32'(item_reg.blob_index) < 32'(blob_count_reg))
                  && (32'(item_reg.blob_index) < 32'(MAX_BLOBS));
    assign cx = (n_reg == '0) ? '0 : (satx_reg ? '1 : qx_reg);
    assign cy = (n_reg == '0) ? '0 : (saty_reg ? '1 : qy_reg);

    always_comb
    begin
        out_next = '0;
        case (item_reg.req_type)
            REQ_PIXEL:
            begin
                out_next.blob_id  = ovf ? '0 : ID_W'(pix_id);
                out_next.is_new   = do_new;
                out_next.overflow = ovf;
            end
            REQ_STATS:
            begin
                if (stat_ok)
                begin
                    out_next.centroid_x = cx;
                    out_next.centroid_y = cy;
                    out_next.area       = n_reg;
                    out_next.stat_valid = 1'b1;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_comb
    begin
        blob_count_next = blob_count_reg;
        if (cmd.finish)
        begin
            if (item_reg.req_type == REQ_CLEAR)
            begin
                blob_count_next = '0;
            end
            else if (do_new)
            begin
                blob_count_next = blob_count_reg + BCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            blob_count_reg <= blob_count_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign status.is_stats = (item_reg.req_type == REQ_STATS);
    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(1));
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.clearing = clearing_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/label_compaction_blob_stats_top.sv
// Blob labelling and statistics block: label compaction to dense blob ids
// with per-blob coordinate sums, pixel counts and centroid readout.
// Depends on lcbs_pkg, lcbs_ctrl and lcbs_dp.
//
// Usage:
//   in_valid/in_stall/in_data carry one request word (pixel, stats, clear).
//   out_valid/out_stall/out_data return exactly one result word per request.
//   One request is in flight at a time; in_stall is high while it is worked.
//   Pixel request: after acceptance the blob entry is read, then it is updated and
//     the result written to the output register; the next word is taken after that.
//   Stats request: after acceptance the blob is read, the divider is loaded, then
//     10 divider steps retire one quotient bit per cycle for x and y together;
//     the result then goes to the output register and the next word follows it.
//   Clear request: same steps as a pixel; it only resets the blob count,
//     because a label entry counts only if it points below the count and that
//     blob's owner entry names the label.
//   Reset: the blob count and the output valid drop at once. The label table
//     is then zeroed one entry per cycle, 2^LABEL_BITS entries (65536 at the
//     default), with in_stall high; requests are taken after that pass.
//   Output stall: the result is held in the output register; the next request
//     may be accepted and worked, but its result waits until the word is taken.
module label_compaction_blob_stats_top #(
    parameter int LABEL_BITS = 16,
    parameter int MAX_BLOBS  = 1024,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lcbs_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output lcbs_pkg::out_t out_data
);
    import lcbs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    busy;

    // sequencer: one request at a time
    lcbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    // memories, accumulators, divider and output register
    lcbs_dp #(
        .LABEL_BITS (LABEL_BITS),
        .MAX_BLOBS  (MAX_BLOBS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // hold off new words while a request is worked or the label table is zeroed
    assign in_stall = busy;

endmodule
